[sv/modified_bessel_i_series_unit_defines.svh]
// Assertion macros used by the block's top-level RTL file.
`ifndef MODIFIED_BESSEL_I_SERIES_UNIT_DEFINES_SVH
`define MODIFIED_BESSEL_I_SERIES_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MBI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MBI_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBI_ASSERT(lbl, clk, rstn, prop, msg)
`define MBI_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[sv/mbi_pkg.sv]
`default_nettype none
package mbi_pkg;
    localparam int SERIES_TERMS_DEF = 20;
    localparam int MAX_ORDER_DEF    = 8;
    localparam int TERM_W           = 64;
    localparam int PROD_W           = 2 * TERM_W;
    localparam int ARG_W            = 32;
    localparam int ORDER_W          = 4;
    localparam int VALUE_W          = 48;
    localparam int ONE_SHIFT        = 40;
    localparam int LEAD_SHIFT       = 29;
    localparam int SER_SHIFT        = 58;
    localparam int DIV_BITS         = 8;
    localparam int DIV_CYCLES       = TERM_W / DIV_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_MUL, ST_RND, ST_DIV, ST_ACC, ST_SEED, ST_FIN
    } mbi_state_t;

    typedef struct packed {
        logic       load;
        logic       mul_step;
        logic       mul_first;
        logic [1:0] part;
        logic       rnd;
        logic       div_step;
        logic       acc;
        logic       seed;
        logic       fin;
    } mbi_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic lead;
        logic k_last;
        logic i_last;
        logic out_busy;
    } mbi_status_t;
endpackage
`default_nettype wire

[sv/mbi_ctrl.sv]
`default_nettype none
module mbi_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  mbi_pkg::mbi_status_t status,
    output mbi_pkg::mbi_cmd_t    cmd
);
    import mbi_pkg::*;

    mbi_state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_START;
            end
            ST_START: begin
                cnt_next   = '0;
                state_next = status.n_zero ? ST_SEED : ST_MUL;
            end
            ST_MUL: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3) begin
                    cnt_next   = '0;
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(DIV_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (status.lead) begin
                    state_next = status.k_last ? ST_SEED : ST_MUL;
                end else begin
                    state_next = status.i_last ? ST_FIN : ST_MUL;
                end
            end
            ST_SEED: begin
                state_next = ST_MUL;
            end
            ST_FIN: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        cmd.part  = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL: begin
                cmd.mul_step  = 1'b1;
                cmd.mul_first = (cnt_reg == 3'd0);
            end
            ST_RND:  cmd.rnd      = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_ACC:  cmd.acc      = 1'b1;
            ST_SEED: cmd.seed     = 1'b1;
            ST_FIN:  cmd.fin      = !status.out_busy;
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

[sv/mbi_datapath.sv]
`default_nettype none
module mbi_datapath #(
    parameter int SERIES_TERMS = mbi_pkg::SERIES_TERMS_DEF,
    parameter int MAX_ORDER    = mbi_pkg::MAX_ORDER_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [mbi_pkg::ORDER_W-1:0]  order,
    input  wire  [mbi_pkg::ARG_W-1:0]    argument,
    input  mbi_pkg::mbi_cmd_t            cmd,
    output mbi_pkg::mbi_status_t         status,
    input  wire                          out_ready,
    output logic                         out_valid,
    output logic [mbi_pkg::VALUE_W-1:0]  value,
    output logic                         saturated
);
    import mbi_pkg::*;

    localparam int IW   = $clog2(SERIES_TERMS);
    localparam int KW   = $clog2(MAX_ORDER + 1);
    localparam int DMAX = (SERIES_TERMS - 1) * (SERIES_TERMS - 1 + MAX_ORDER);
    localparam int DW   = $clog2(DMAX + 1);

    logic [KW-1:0]     n_reg, k_reg;
    logic [IW-1:0]     i_reg;
    logic [ARG_W-1:0]  x_reg;
    logic [TERM_W-1:0] xsq_reg, term_reg, sum_reg, quo_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DW-1:0]     dvs_reg, rem_reg;
    logic              lead_reg, ovf_reg, out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic              sat_reg;

    logic [TERM_W-1:0] b_op;
    logic [31:0]       a_half, b_half;
    logic [63:0]       pp;
    logic [PROD_W-1:0] pp_sh, prod_next;
    logic [PROD_W-1:0] rsum;
    logic              rnd_ovf;
    logic [TERM_W-1:0] rnd_res;
    logic [DW-1:0]     dvs_next;
    logic [TERM_W-1:0] quo_next;
    logic [DW-1:0]     rem_next;
    logic [DW:0]       rr;
    logic              q_up;
    logic [TERM_W-1:0] term_new;
    logic [TERM_W:0]   sum_wide;
    logic [56:0]       val_w;

    assign status.n_zero   = (n_reg == '0);
    assign status.lead     = lead_reg;
    assign status.k_last   = (k_reg == n_reg);
    assign status.i_last   = (i_reg == IW'(SERIES_TERMS - 1));
    assign status.out_busy = out_valid_reg && !out_ready;

    // Partial products of the 64 by 64 multiply, one 32 by 32 slice per cycle.
    always_comb begin
        b_op   = lead_reg ? {32'd0, x_reg} : xsq_reg;
        a_half = cmd.part[1] ? term_reg[63:32] : term_reg[31:0];
        b_half = cmd.part[0] ? b_op[63:32] : b_op[31:0];
        pp     = 64'(a_half) * 64'(b_half);
        case (cmd.part)
            2'd0:    pp_sh = PROD_W'(pp);
            2'd3:    pp_sh = PROD_W'(pp) << 64;
            default: pp_sh = PROD_W'(pp) << 32;
        endcase
        prod_next = (cmd.mul_first ? '0 : prod_reg) + pp_sh;
    end

    always_comb begin
        if (lead_reg) begin
            rsum    = prod_reg + (PROD_W'(1) << (LEAD_SHIFT - 1));
            rnd_ovf = |rsum[PROD_W-1:TERM_W+LEAD_SHIFT];
            rnd_res = rsum[TERM_W+LEAD_SHIFT-1:LEAD_SHIFT];
            dvs_next = DW'(k_reg);
        end else begin
            rsum    = prod_reg + (PROD_W'(1) << (SER_SHIFT - 1));
            rnd_ovf = |rsum[PROD_W-1:TERM_W+SER_SHIFT];
            rnd_res = rsum[TERM_W+SER_SHIFT-1:SER_SHIFT];
            dvs_next = DW'(i_reg) * (DW'(i_reg) + DW'(n_reg));
        end
    end

    // Restoring division, a byte of quotient per cycle.
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        rr       = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            rr       = {rem_next, quo_next[TERM_W-1]};
            quo_next = quo_next << 1;
            if (rr >= {1'b0, dvs_reg}) begin
                rem_next    = DW'(rr - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = rr[DW-1:0];
            end
        end
    end

    always_comb begin
        q_up     = ({rem_reg, 1'b0} >= {1'b0, dvs_reg});
        term_new = quo_reg + TERM_W'(q_up);
        sum_wide = {1'b0, sum_reg} + {1'b0, term_new};
        val_w    = 57'(sum_reg[63:8]) + 57'(sum_reg[7]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg    <= (32'(order) > MAX_ORDER) ? KW'(MAX_ORDER) : KW'(order);
            x_reg    <= argument;
            xsq_reg  <= 64'(argument) * 64'(argument);
            term_reg <= TERM_W'(1) << ONE_SHIFT;
            k_reg    <= KW'(1);
            i_reg    <= IW'(1);
            lead_reg <= 1'b1;
            ovf_reg  <= 1'b0;
        end
        if (cmd.mul_step) prod_reg <= prod_next;
        if (cmd.rnd) begin
            quo_reg <= rnd_res;
            rem_reg <= '0;
            dvs_reg <= dvs_next;
            if (rnd_ovf) ovf_reg <= 1'b1;
        end
        if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.acc) begin
            term_reg <= term_new;
            if (lead_reg) begin
                k_reg <= k_reg + KW'(1);
            end else begin
                sum_reg <= sum_wide[TERM_W-1:0];
                i_reg   <= i_reg + IW'(1);
                if (sum_wide[TERM_W]) ovf_reg <= 1'b1;
            end
        end
        if (cmd.seed) begin
            sum_reg  <= term_reg;
            lead_reg <= 1'b0;
        end
        if (cmd.fin) begin
            if (ovf_reg || (|val_w[56:VALUE_W])) begin
                value_reg <= '1;
                sat_reg   <= 1'b1;
            end else begin
                value_reg <= val_w[VALUE_W-1:0];
                sat_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;
endmodule
`default_nettype wire

[sv/modified_bessel_i_series_unit.sv]
// Computes I_n(x) by a truncated power series on one shared multiply and divide
// datapath. Each term takes four 32 by 32 partial products, one rounding step,
// eight steps of byte-wide restoring division and one accumulate step. An item
// with clamped order n runs n + SERIES_TERMS - 1 such term steps, and one item
// is worked on at a time. The input is taken again once the result has been
// moved to the output register.
`default_nettype none
`include "modified_bessel_i_series_unit_defines.svh"
module modified_bessel_i_series_unit #(
    parameter int SERIES_TERMS = mbi_pkg::SERIES_TERMS_DEF,
    parameter int MAX_ORDER    = mbi_pkg::MAX_ORDER_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // order [3:0], argument [35:4], zero [39:36]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // value [47:0]
    output logic [0:0]  m_tuser    // saturated [0]
);
    import mbi_pkg::*;

    mbi_cmd_t    cmd;
    mbi_status_t status;
    logic        sat;

    mbi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbi_datapath #(
        .SERIES_TERMS (SERIES_TERMS),
        .MAX_ORDER    (MAX_ORDER)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .order     (s_tdata[3:0]),
        .argument  (s_tdata[35:4]),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .value     (m_tdata),
        .saturated (sat)
    );

    assign m_tuser = sat;

    `MBI_ASSERT(a_sat_all_ones, aclk, aresetn, m_tvalid && m_tuser[0] |-> (&m_tdata), "saturated item without all-ones value")
    `MBI_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken twice in a row")
    `MBI_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TERMS = 20;
    localparam int ORDER_CAP = 8;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    // Packed from the top down, so the order lands in the lowest bits as on s_tdata.
    typedef struct packed {
        logic [31:0] argument;
        logic [3:0]  order;
    } bessel_req_t;

    typedef struct packed {
        logic [47:0] value;
        logic        saturated;
    } bessel_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [47:0] m_tdata;
    wire  [0:0]  m_tuser;

    modified_bessel_i_series_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    bessel_req_t pending_reqs[$];
    bessel_res_t expected_vals[$];
    bit          stim_done = 1'b0;
    bit          calm = 1'b0;
    int          errors = 0;
    longint      cycles = 0;
    int          src_gap = 0;
    int          sink_gap = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Rounded (a*b) >> s; flags overflow when the high part does not fit.
    function automatic logic [63:0] rnd_mul(input logic [63:0] a, input logic [63:0] b,
                                            input int s, inout bit ovf);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        if (p[127:64] != 0) begin
            ovf = 1'b1;
            return '1;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] rnd_div(input logic [63:0] p, input logic [63:0] d);
        logic [63:0] q, r;
        q = p / d;
        r = p % d;
        if (r >= d - r) q++;
        return q;
    endfunction

    function automatic bessel_res_t bessel_series(input bessel_req_t req);
        logic [63:0] xsq, term, sum, val;
        logic [63:0] n;
        bit ovf;
        bessel_res_t res;
        ovf = 1'b0;
        n = req.order;
        if (n > ORDER_CAP) n = ORDER_CAP;
        xsq = {32'd0, req.argument} * {32'd0, req.argument};
        term = 64'd1 << 40;
        for (int k = 1; k <= n; k++) begin
            term = rnd_mul(term, {32'd0, req.argument}, 29, ovf);
            term = rnd_div(term, k);
        end
        sum = term;
        for (int i = 1; i < NUM_TERMS; i++) begin
            term = rnd_mul(term, xsq, 58, ovf);
            term = rnd_div(term, i * (i + n));
            if (sum + term < sum) ovf = 1'b1;
            sum = sum + term;
        end
        val = (sum >> 8) + ((sum >> 7) & 64'd1);
        if (ovf || val > 64'hFFFF_FFFF_FFFF) begin
            res.value = '1;
            res.saturated = 1'b1;
        end else begin
            res.value = val[47:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_argument();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'h8000_0000 - $urandom_range(0, 1000);
            3: return $urandom_range(0, 32'h1000_0000);
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    function automatic void add_req(input logic [3:0] ord, input logic [31:0] arg);
        bessel_req_t r;
        r.order = ord;
        r.argument = arg;
        pending_reqs = {pending_reqs, r};
    endfunction

    initial begin
        for (int n = 0; n < 16; n++) begin
            add_req(4'(n), (n % 3 == 0) ? 32'h0 : (n % 3 == 1) ? 32'h8000_0000
                                                               : 32'hFFFF_FFFF);
        end
        add_req(4'd0, 32'h1000_0000);
        add_req(4'd1, 32'h0000_0001);
        add_req(4'd8, 32'h7FFF_FFFF);
        add_req(4'd0, 32'hFFFF_FFFF);
        add_req(4'd15, 32'h5555_5555);
        add_req(4'd2, 32'hAAAA_AAAA);
        for (int j = 0; j < 1900; j++) begin
            add_req(($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8)),
                    pick_argument());
        end
        stim_done = 1'b1;
    end

    // Driver: presents items from the queue, with random bursts of idle cycles while 150 or more are queued.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == 11) aresetn <= 1'b1;
        calm <= (pending_reqs.size() < 150);
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_vals = {expected_vals, bessel_series(s_tdata[35:0])};
                void'(pending_reqs.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        src_gap <= $urandom_range(0, 7);
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata <= {4'd0, pending_reqs[0]};
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and sink: random back-pressure while 150 or more items are queued, results checked in order.
    always @(posedge aclk) begin
        bessel_res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_vals.size() == 0) begin
                    $error("result item with nothing expected: value %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_vals.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("value: expected %h, actual %h", want.value, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.saturated) begin
                        $error("saturated: expected %b, actual %b", want.saturated, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                sink_gap <= $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (stim_done);
        while ((pending_reqs.size() != 0 || expected_vals.size() != 0 || s_tvalid)
               && cycles < CYCLE_LIMIT)
            @(posedge aclk);
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            repeat (400) @(posedge aclk);
            if (errors == 0 && expected_vals.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
`default_nettype wire
